// ===== hdl/gcdtd_pkg.sv =====
// Package for the GCD block: operand widths, stream widths, sequencer states,
// datapath operation codes and the control/status structs between the parts.
// No dependencies.
`default_nettype none

package gcdtd_pkg;

  localparam int OPERAND_BITS  = 31;
  localparam int SHIFT_BITS    = $clog2(OPERAND_BITS);
  localparam int IN_TDATA_BITS = ((2 * OPERAND_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((OPERAND_BITS + 7) / 8) * 8;

  typedef logic [OPERAND_BITS-1:0] operand_t;
  typedef logic [SHIFT_BITS-1:0]   shift_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STRIP,
    ST_REDUCE,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_ONE,
    OP_HALVE_BOTH,
    OP_HALVE_A,
    OP_HALVE_B,
    OP_SUB_A,
    OP_SWAP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   double_a;
    logic   out_load;
  } ctrl_t;

  typedef struct packed {
    logic a_lsb;
    logic b_lsb;
    logic equal;
    logic a_ge_b;
    logic k_zero;
    logic below_two;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/gcdtd_datapath.sv =====
// Operand registers, common-factor shift count and the shared subtract/shift
// unit of the binary GCD iteration. Depends on gcdtd_pkg.
`default_nettype none

module gcdtd_datapath (
  input  wire logic               clk,
  input  wire gcdtd_pkg::ctrl_t   ctrl,
  input  wire gcdtd_pkg::operand_t load_a,
  input  wire gcdtd_pkg::operand_t load_b,
  output gcdtd_pkg::status_t      status,
  output gcdtd_pkg::operand_t     result
);
  import gcdtd_pkg::*;

  operand_t a_r, a_nxt;
  operand_t b_r, b_nxt;
  shift_t   k_r, k_nxt;
  logic [OPERAND_BITS:0] diff;

  // The one subtractor serves both as comparator and as reducer.
  assign diff = {1'b0, a_r} - {1'b0, b_r};

  always_comb begin
    status.a_lsb     = a_r[0];
    status.b_lsb     = b_r[0];
    status.equal     = (diff == '0);
    status.a_ge_b    = !diff[OPERAND_BITS];
    status.k_zero    = (k_r == '0);
    status.below_two = (a_r[OPERAND_BITS-1:1] == '0) || (b_r[OPERAND_BITS-1:1] == '0);
  end

  assign result = a_r;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    k_nxt = k_r;
    if (ctrl.double_a) begin
      a_nxt = {a_r[OPERAND_BITS-2:0], 1'b0};
      k_nxt = k_r - shift_t'(1);
    end else begin
      case (ctrl.op)
        OP_HOLD: begin
        end
        OP_LOAD: begin
          a_nxt = load_a;
          b_nxt = load_b;
          k_nxt = '0;
        end
        OP_ONE: begin
          a_nxt = operand_t'(1);
          k_nxt = '0;
        end
        OP_HALVE_BOTH: begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + shift_t'(1);
        end
        OP_HALVE_A: begin
          a_nxt = a_r >> 1;
        end
        OP_HALVE_B: begin
          b_nxt = b_r >> 1;
        end
        OP_SUB_A: begin
          a_nxt = {1'b0, diff[OPERAND_BITS-1:1]};
        end
        OP_SWAP: begin
          a_nxt = b_r;
          b_nxt = a_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/gcdtd_ctrl.sv =====
// Sequencer of the binary GCD iteration: strips common factors of two,
// reduces odd operands by subtraction, then scales the result back.
// An operand below two yields a result of one. Depends on gcdtd_pkg.
`default_nettype none

module gcdtd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              out_busy,
  input  wire gcdtd_pkg::status_t status,
  output gcdtd_pkg::ctrl_t       ctrl,
  output logic                   idle
);
  import gcdtd_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = status.below_two ? ST_DONE : ST_STRIP;
      end
      ST_STRIP: begin
        if (status.a_lsb || status.b_lsb) begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status.a_lsb && status.b_lsb && status.equal) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (status.k_zero) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.double_a = 1'b0;
    ctrl.out_load = 1'b0;
    idle          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idle    = 1'b1;
        ctrl.op = in_valid ? OP_LOAD : OP_HOLD;
      end
      ST_CHECK: begin
        ctrl.op = status.below_two ? OP_ONE : OP_HOLD;
      end
      ST_STRIP: begin
        if (!status.a_lsb && !status.b_lsb) begin
          ctrl.op = OP_HALVE_BOTH;
        end
      end
      ST_REDUCE: begin
        if (!status.a_lsb) begin
          ctrl.op = OP_HALVE_A;
        end else if (!status.b_lsb) begin
          ctrl.op = OP_HALVE_B;
        end else if (status.equal) begin
          ctrl.op = OP_HOLD;
        end else if (status.a_ge_b) begin
          ctrl.op = OP_SUB_A;
        end else begin
          ctrl.op = OP_SWAP;
        end
      end
      ST_SCALE: begin
        ctrl.double_a = !status.k_zero;
      end
      ST_DONE: begin
        ctrl.out_load = !out_busy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gcd_trial_division.sv =====
// Greatest common divisor of two unsigned operands by the binary method on
// one shared subtract/shift unit; the result is one when either operand is
// below 2. The next input beat is taken in the cycle after the result leaves
// the sequencer, so the block works on one item at a time. Reset (rst_n low,
// synchronous) returns the sequencer to idle and empties the output register.
// Depends on gcdtd_pkg, gcdtd_ctrl and gcdtd_datapath.
`default_nettype none

module gcd_trial_division (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // first_value, second_value, zero padding
  input  wire logic [gcdtd_pkg::IN_TDATA_BITS-1:0]  in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // divisor_result, zero padding
  output logic [gcdtd_pkg::OUT_TDATA_BITS-1:0]      out_tdata
);
  import gcdtd_pkg::*;

  ctrl_t    ctrl;
  status_t  status;
  operand_t result;
  logic     idle;
  logic     out_valid_r;
  operand_t out_data_r;

  gcdtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_busy (out_valid_r && !out_tready),
    .status   (status),
    .ctrl     (ctrl),
    .idle     (idle)
  );

  gcdtd_datapath u_datapath (
    .clk    (clk),
    .ctrl   (ctrl),
    .load_a (in_tdata[OPERAND_BITS-1:0]),
    .load_b (in_tdata[2*OPERAND_BITS-1:OPERAND_BITS]),
    .status (status),
    .result (result)
  );

  assign in_tready  = idle;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_BITS'(out_data_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data_r <= result;
    end
  end

endmodule

`default_nettype wire
